[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the lease guard modules. Each macro samples on
// clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define CLG_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CLG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/clg_pkg.sv]
// ----------------------------------------------------------------------------
// clg_pkg
// Shared types, command codes, constants, token helpers and a wrap-safe time compare.
// ----------------------------------------------------------------------------
package clg_pkg;

  // Field widths
  localparam int unsigned TOKEN_W   = 64;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned AXES_W    = 64;
  localparam int unsigned IN_DATA_W  = 328;
  localparam int unsigned OUT_DATA_W = 200;
  localparam int unsigned CFG_IDX_W = 1;

  // Token and axis layout
  localparam int unsigned TOKEN_BYTES = 8;
  localparam int unsigned TOKEN_MAX_BYTES = 8;
  localparam int unsigned AXIS_BITS = 16;
  localparam int unsigned SLOT_BITS = 16;
  localparam int unsigned LANES     = 4;
  localparam logic [SLOT_BITS-1:0] LANE_MASK =
    SLOT_BITS'((17'(1) << AXIS_BITS) - 17'(1));
  localparam logic signed [AXIS_BITS-1:0] AXIS_ONE =
    AXIS_BITS'(1) << (AXIS_BITS - 2);
  localparam logic signed [AXIS_BITS-1:0] AXIS_NEG_ONE = -AXIS_ONE;

  // Register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEASE     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_TIMEOUT = 1'd1;
  localparam logic [TIME_W-1:0] MAX_LEASE_RST     = 32'd30000;
  localparam logic [TIME_W-1:0] FRAME_TIMEOUT_RST = 32'd500;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_GRANT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FRAME   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_NEUTRAL = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [TOKEN_W-1:0] token;
    logic [TIME_W-1:0]  now_ms;
    logic [TIME_W-1:0]  lease_ms;
    logic [TIME_W-1:0]  sequence_req;
    logic [MODE_W-1:0]  mode;
    logic [AXES_W-1:0]  axes_low;
    logic [AXES_W-1:0]  axes_high;
    logic [TIME_W-1:0]  quoted_timeout_ms;
    logic               prereq_ok;
  } item_t;

  // Packed so that accepted lands in bit 0 of the result word
  typedef struct packed {
    logic [TIME_W-1:0] lease_left_ms;
    logic [TIME_W-1:0] frame_age_ms;
    logic [AXES_W-1:0] snap_axes_high;
    logic [AXES_W-1:0] snap_axes_low;
    logic [MODE_W-1:0] snap_mode;
    logic              deadman;
    logic              snap_active;
    logic              authority;
    logic              accepted;
  } result_t;

  typedef struct packed {
    logic [TIME_W-1:0] max_lease_ms;
    logic [TIME_W-1:0] frame_timeout_ms;
  } cfg_t;

  // Cut a token at its first zero byte
  function automatic logic [TOKEN_W-1:0] norm_token(input logic [TOKEN_W-1:0] t);
    logic [TOKEN_W-1:0] r;
    logic               alive;
    r     = '0;
    alive = 1'b1;
    for (int i = 0; i < TOKEN_MAX_BYTES; i++) begin
      alive = alive && (t[8*i +: 8] != 8'd0);
      if (alive) r[8*i +: 8] = t[8*i +: 8];
    end
    return r;
  endfunction

  // Number of leading nonzero bytes
  function automatic logic [3:0] token_len(input logic [TOKEN_W-1:0] t);
    logic [3:0] len;
    logic       alive;
    len   = '0;
    alive = 1'b1;
    for (int i = 0; i < TOKEN_MAX_BYTES; i++) begin
      alive = alive && (t[8*i +: 8] != 8'd0);
      if (alive) len = len + 4'd1;
    end
    return len;
  endfunction

  // Wrap-safe "now is before deadline"
  function automatic logic is_before(input logic [TIME_W-1:0] now_t,
                                     input logic [TIME_W-1:0] deadline);
    logic [TIME_W-1:0] d;
    d = deadline - now_t;
    return (d != '0) && !d[TIME_W-1];
  endfunction

endpackage

[rtl/core/clg_lane_check.sv]
// ----------------------------------------------------------------------------
// clg_lane_check
// Range check of four Q1.14 axis lanes against +-1, with each lane masked
// to its axis width for storage.
// ----------------------------------------------------------------------------
module clg_lane_check (
  input  logic [clg_pkg::AXES_W-1:0] lane_word,
  output logic                       lanes_ok,
  output logic [clg_pkg::AXES_W-1:0] lane_masked
);

  logic [clg_pkg::SLOT_BITS-1:0]        slot;
  logic signed [clg_pkg::AXIS_BITS-1:0] val;

  // Lanes are independent: check and mask each one
  always_comb begin
    lanes_ok    = 1'b1;
    lane_masked = '0;
    slot        = '0;
    val         = '0;
    for (int i = 0; i < clg_pkg::LANES; i++) begin
      slot = lane_word[i*clg_pkg::SLOT_BITS +: clg_pkg::SLOT_BITS] & clg_pkg::LANE_MASK;
      val  = slot[clg_pkg::AXIS_BITS-1:0];
      if (val < clg_pkg::AXIS_NEG_ONE || val > clg_pkg::AXIS_ONE) lanes_ok = 1'b0;
      lane_masked[i*clg_pkg::SLOT_BITS +: clg_pkg::SLOT_BITS] = slot;
    end
  end

endmodule

[rtl/core/clg_core.sv]
// ----------------------------------------------------------------------------
// clg_core
// Lease and snapshot state with the per-command decision logic. One word is
// evaluated per cycle when fire is high; the result reflects the new state.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module clg_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  clg_pkg::item_t   item,
  input  clg_pkg::cfg_t    cfg,
  output clg_pkg::result_t res
);

  // State registers
  logic                        held_r, held_nxt;
  logic [clg_pkg::TOKEN_W-1:0] held_token_r, held_token_nxt;
  logic [clg_pkg::TIME_W-1:0]  expiry_r, expiry_nxt;
  logic [clg_pkg::TIME_W-1:0]  last_frame_r, last_frame_nxt;
  logic                        frame_seen_r, frame_seen_nxt;
  logic                        seq_valid_r, seq_valid_nxt;
  logic [clg_pkg::TIME_W-1:0]  last_seq_r, last_seq_nxt;
  logic                        snap_active_r, snap_active_nxt;
  logic                        deadman_r, deadman_nxt;
  logic [clg_pkg::MODE_W-1:0]  snap_mode_r, snap_mode_nxt;
  logic [clg_pkg::AXES_W-1:0]  snap_lo_r, snap_lo_nxt;
  logic [clg_pkg::AXES_W-1:0]  snap_hi_r, snap_hi_nxt;

  logic                        acc;
  logic                        lo_ok, hi_ok;
  logic [clg_pkg::AXES_W-1:0]  lo_masked, hi_masked;
  logic [clg_pkg::TOKEN_W-1:0] tok_norm;
  logic [3:0]                  tok_len;
  logic                        tok_match;
  logic                        unexpired;
  logic                        seq_fresh;
  logic [clg_pkg::TIME_W-1:0]  idle_age;
  logic [clg_pkg::TIME_W-1:0]  age_nxt;
  logic [clg_pkg::TIME_W-1:0]  left_nxt;

  clg_lane_check u_lane_lo (
    .lane_word   (item.axes_low),
    .lanes_ok    (lo_ok),
    .lane_masked (lo_masked)
  );

  clg_lane_check u_lane_hi (
    .lane_word   (item.axes_high),
    .lanes_ok    (hi_ok),
    .lane_masked (hi_masked)
  );

  // Common checks
  assign tok_norm  = clg_pkg::norm_token(item.token);
  assign tok_len   = clg_pkg::token_len(item.token);
  assign tok_match = held_r && (tok_norm == held_token_r);
  assign unexpired = clg_pkg::is_before(item.now_ms, expiry_r);
  assign seq_fresh = !seq_valid_r || (item.sequence_req > last_seq_r);
  assign idle_age  = item.now_ms - last_frame_r;

  // Command decode and next state
  always_comb begin
    held_nxt        = held_r;
    held_token_nxt  = held_token_r;
    expiry_nxt      = expiry_r;
    last_frame_nxt  = last_frame_r;
    frame_seen_nxt  = frame_seen_r;
    seq_valid_nxt   = seq_valid_r;
    last_seq_nxt    = last_seq_r;
    snap_active_nxt = snap_active_r;
    deadman_nxt     = deadman_r;
    snap_mode_nxt   = snap_mode_r;
    snap_lo_nxt     = snap_lo_r;
    snap_hi_nxt     = snap_hi_r;
    acc             = 1'b0;
    if (fire) begin
      case (item.cmd)
        clg_pkg::CMD_GRANT: begin
          if (!held_r && tok_len != 4'd0 && tok_len <= 4'(clg_pkg::TOKEN_BYTES) &&
              item.lease_ms != '0 && item.lease_ms <= cfg.max_lease_ms) begin
            held_token_nxt  = tok_norm;
            held_nxt        = 1'b1;
            expiry_nxt      = item.now_ms + item.lease_ms;
            last_frame_nxt  = item.now_ms;
            frame_seen_nxt  = 1'b0;
            seq_valid_nxt   = 1'b0;
            last_seq_nxt    = '0;
            snap_active_nxt = 1'b0;
            deadman_nxt     = 1'b0;
            snap_mode_nxt   = '0;
            snap_lo_nxt     = '0;
            snap_hi_nxt     = '0;
            acc             = 1'b1;
          end
        end
        clg_pkg::CMD_RELEASE: begin
          if (tok_match) begin
            held_nxt        = 1'b0;
            held_token_nxt  = '0;
            expiry_nxt      = '0;
            frame_seen_nxt  = 1'b0;
            last_frame_nxt  = '0;
            seq_valid_nxt   = 1'b0;
            last_seq_nxt    = '0;
            snap_active_nxt = 1'b0;
            deadman_nxt     = 1'b0;
            snap_mode_nxt   = '0;
            snap_lo_nxt     = '0;
            snap_hi_nxt     = '0;
            acc             = 1'b1;
          end
        end
        clg_pkg::CMD_FRAME: begin
          if (tok_match && unexpired && item.quoted_timeout_ms == cfg.frame_timeout_ms &&
              seq_fresh && lo_ok && hi_ok) begin
            snap_active_nxt = 1'b1;
            deadman_nxt     = 1'b1;
            snap_mode_nxt   = item.mode;
            snap_lo_nxt     = lo_masked;
            snap_hi_nxt     = hi_masked;
            frame_seen_nxt  = 1'b1;
            last_frame_nxt  = item.now_ms;
            last_seq_nxt    = item.sequence_req;
            seq_valid_nxt   = 1'b1;
            acc             = 1'b1;
          end
        end
        clg_pkg::CMD_NEUTRAL: begin
          // Neutralize while held: snapshot zero but active
          if (held_r) begin
            snap_active_nxt = 1'b1;
            deadman_nxt     = 1'b0;
            snap_mode_nxt   = '0;
            snap_lo_nxt     = '0;
            snap_hi_nxt     = '0;
            frame_seen_nxt  = 1'b1;
            last_frame_nxt  = item.now_ms;
          end
        end
        clg_pkg::CMD_TICK: begin
          if (held_r) begin
            if (!item.prereq_ok || !unexpired) begin
              // Revoke
              held_nxt        = 1'b0;
              held_token_nxt  = '0;
              expiry_nxt      = '0;
              frame_seen_nxt  = 1'b0;
              last_frame_nxt  = '0;
              seq_valid_nxt   = 1'b0;
              last_seq_nxt    = '0;
              snap_active_nxt = 1'b0;
              deadman_nxt     = 1'b0;
              snap_mode_nxt   = '0;
              snap_lo_nxt     = '0;
              snap_hi_nxt     = '0;
            end else if (frame_seen_r && idle_age > cfg.frame_timeout_ms) begin
              // Stale snapshot: neutralize
              snap_active_nxt = 1'b1;
              deadman_nxt     = 1'b0;
              snap_mode_nxt   = '0;
              snap_lo_nxt     = '0;
              snap_hi_nxt     = '0;
              frame_seen_nxt  = 1'b1;
              last_frame_nxt  = item.now_ms;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Status after the update
  assign age_nxt  = item.now_ms - last_frame_nxt;
  assign left_nxt = expiry_nxt - item.now_ms;

  always_comb begin
    res.accepted       = acc;
    res.authority      = held_nxt;
    res.snap_active    = snap_active_nxt;
    res.deadman        = deadman_nxt;
    res.snap_mode      = snap_mode_nxt;
    res.snap_axes_low  = snap_lo_nxt;
    res.snap_axes_high = snap_hi_nxt;
    res.frame_age_ms   = frame_seen_nxt ? age_nxt : '0;
    res.lease_left_ms  = (held_nxt && left_nxt != '0 && !left_nxt[clg_pkg::TIME_W-1]) ?
                         left_nxt : '0;
  end

  // State update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r        <= 1'b0;
      held_token_r  <= '0;
      expiry_r      <= '0;
      last_frame_r  <= '0;
      frame_seen_r  <= 1'b0;
      seq_valid_r   <= 1'b0;
      last_seq_r    <= '0;
      snap_active_r <= 1'b0;
      deadman_r     <= 1'b0;
      snap_mode_r   <= '0;
      snap_lo_r     <= '0;
      snap_hi_r     <= '0;
    end else begin
      held_r        <= held_nxt;
      held_token_r  <= held_token_nxt;
      expiry_r      <= expiry_nxt;
      last_frame_r  <= last_frame_nxt;
      frame_seen_r  <= frame_seen_nxt;
      seq_valid_r   <= seq_valid_nxt;
      last_seq_r    <= last_seq_nxt;
      snap_active_r <= snap_active_nxt;
      deadman_r     <= deadman_nxt;
      snap_mode_r   <= snap_mode_nxt;
      snap_lo_r     <= snap_lo_nxt;
      snap_hi_r     <= snap_hi_nxt;
    end
  end

  // Snapshot and frame tracking only exist under a lease
  `CLG_ASSERT_IMPL(a_idle_clean, !held_r, !snap_active_r && !frame_seen_r && !seq_valid_r,
    "snapshot or frame state present without a lease")
  `CLG_ASSERT_IMPL(a_deadman_active, deadman_r, snap_active_r,
    "deadman set on an inactive snapshot")
  `CLG_ASSERT_IMPL(a_active_seen, snap_active_r, frame_seen_r,
    "active snapshot without frame tracking")
  `CLG_ASSERT_NEXT(a_grant_holds, fire && item.cmd == clg_pkg::CMD_GRANT && acc,
    held_r && !frame_seen_r, "accepted grant did not take the lease")

endmodule

[rtl/core/control_lease_guard.sv]
// ----------------------------------------------------------------------------
// control_lease_guard
// Guard for a leased manual-control channel: grant, release, frame, neutral
// and tick commands, one status word out per command word in.
//   Command words enter on the in_ stream; in_tuser carries the command code
//   and in_tdata the operands. Each accepted word yields exactly one status
//   word on the out_ stream, in order.
//   An accepted word passes through one input register, then the
//   lease/snapshot decision logic feeding the output register, which drives
//   out_tvalid. Throughput is one word per cycle while out_tready stays high;
//   the lease state is updated as a word moves from the input register to the
//   output register, so the next word already sees it.
//   When the receiver stalls, the output register holds its word and the
//   input register can still take one more word; in_tready drops only when
//   both are full.
//   Reset (rst_n low, synchronous) drops the lease, clears the snapshot and
//   both stages, and loads max_lease_ms = 30000 and frame_timeout_ms = 500.
//   Configuration writes (cfg_wr_en) take effect on the next cycle and are
//   meant to occur while no command word is in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module control_lease_guard (
  input  logic                              clk,
  input  logic                              rst_n,
  // Command stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata, low bit up: token(64) now_ms(32) lease_ms(32) sequence_req(32) mode(3)
  //   axes_low(64) axes_high(64) quoted_timeout_ms(32) prereq_ok(1) pad(4)
  input  logic [clg_pkg::IN_DATA_W-1:0]     in_tdata,
  // tuser: cmd(3)
  input  logic [clg_pkg::CMD_W-1:0]         in_tuser,
  // Status stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tdata, low bit up: accepted(1) authority(1) snap_active(1) deadman(1)
  //   snap_mode(3) snap_axes_low(64) snap_axes_high(64) frame_age_ms(32)
  //   lease_left_ms(32) pad(1)
  output logic [clg_pkg::OUT_DATA_W-1:0]    out_tdata,
  // Configuration write port
  input  logic                              cfg_wr_en,
  input  logic [clg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [clg_pkg::TIME_W-1:0]        cfg_wdata
);

  logic             s1_valid_r, s1_valid_nxt;
  clg_pkg::item_t   s1_item_r;
  clg_pkg::item_t   in_item;
  logic             out_valid_r, out_valid_nxt;
  clg_pkg::result_t out_res_r;
  clg_pkg::result_t core_res;
  clg_pkg::cfg_t    cfg_r;
  logic             advance;
  logic             fire;

  // Unpack the incoming word
  always_comb begin
    in_item.cmd               = in_tuser;
    in_item.token             = in_tdata[63:0];
    in_item.now_ms            = in_tdata[95:64];
    in_item.lease_ms          = in_tdata[127:96];
    in_item.sequence_req      = in_tdata[159:128];
    in_item.mode              = in_tdata[162:160];
    in_item.axes_low          = in_tdata[226:163];
    in_item.axes_high         = in_tdata[290:227];
    in_item.quoted_timeout_ms = in_tdata[322:291];
    in_item.prereq_ok         = in_tdata[323];
  end

  // Pipeline flow control
  assign advance   = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tready) s1_valid_nxt = in_tvalid;
    out_valid_nxt = out_valid_r;
    if (fire) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) s1_item_r <= in_item;
    if (fire) out_res_r <= core_res;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_lease_ms     <= clg_pkg::MAX_LEASE_RST;
      cfg_r.frame_timeout_ms <= clg_pkg::FRAME_TIMEOUT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        clg_pkg::REG_MAX_LEASE:     cfg_r.max_lease_ms     <= cfg_wdata;
        clg_pkg::REG_FRAME_TIMEOUT: cfg_r.frame_timeout_ms <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  clg_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (s1_item_r),
    .cfg   (cfg_r),
    .res   (core_res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r};

  // A result only appears after a word left the input register
  `CLG_ASSERT_IMPL(a_out_from_s1, $rose(out_valid_r), $past(s1_valid_r),
    "output word without a preceding input word")
  // A blocked input word stays put
  `CLG_ASSERT_NEXT(a_s1_hold, s1_valid_r && !advance,
    s1_valid_r && $stable(s1_item_r), "blocked input word changed")

endmodule

[tb/lease_guard_checker.sv]
// ----------------------------------------------------------------------------
// lease_guard_checker
// Watches the command, status and configuration ports of the lease guard.
// Keeps its own copy of the lease, sequence and snapshot state, works out the
// status word due for every accepted command word and compares each accepted
// status word against the oldest one due, field by field.
// ----------------------------------------------------------------------------
module lease_guard_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [clg_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [clg_pkg::CMD_W-1:0]      in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [clg_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_wr_en,
  input  logic [clg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [clg_pkg::TIME_W-1:0]     cfg_wdata,
  output int unsigned                    fail_count,
  output int unsigned                    outstanding
);
  import clg_pkg::*;

  localparam int LANE_W   = AXIS_BITS;
  localparam int LANE_ONE = 1 << (LANE_W - 2);

  // Shadow configuration
  logic [31:0] cfg_max_lease;
  logic [31:0] cfg_frame_timeout;

  // Shadow lease and snapshot state
  logic        lease_held;
  logic [63:0] lease_token;
  logic [31:0] lease_expiry;
  logic [31:0] last_frame_ms;
  logic        frame_seen;
  logic        seq_valid;
  logic [31:0] last_seq;
  logic        snap_active;
  logic        snap_deadman;
  logic [2:0]  snap_mode;
  logic [63:0] snap_lo;
  logic [63:0] snap_hi;

  result_t     status_due [$];
  item_t       seen_cmd;
  result_t     want_s;
  result_t     got_s;
  logic [3:0]  pad_bits;
  int unsigned words_checked;

  // Wrap-safe "now lies before deadline"
  function automatic bit ahead_of(input logic [31:0] now_t, input logic [31:0] deadline);
    logic [31:0] d;
    d = deadline - now_t;
    return (d != 32'd0) && (d < 32'h8000_0000);
  endfunction

  // Token as a string: bytes up to the first zero byte
  function automatic logic [63:0] trim_token(input logic [63:0] t, output int unsigned n);
    logic [63:0] r;
    bit          ended;
    r     = '0;
    n     = 0;
    ended = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (t[8*i +: 8] == 8'd0) ended = 1'b1;
      if (!ended) begin
        r[8*i +: 8] = t[8*i +: 8];
        n = i + 1;
      end
    end
    return r;
  endfunction

  // All four lanes within +-1.0; also hands back the lanes cut to LANE_W bits
  function automatic bit lanes_in_range(input logic [63:0] w, output logic [63:0] m);
    int u;
    int v;
    bit ok;
    ok = 1'b1;
    m  = '0;
    for (int i = 0; i < 4; i++) begin
      u = int'(w[16*i +: 16]) & ((1 << LANE_W) - 1);
      v = u;
      if (u >= (1 << (LANE_W - 1))) v = u - (1 << LANE_W);
      if (v < -LANE_ONE || v > LANE_ONE) ok = 1'b0;
      m[16*i +: 16] = 16'(u);
    end
    return ok;
  endfunction

  task automatic clear_snap();
    snap_active  = 1'b0;
    snap_deadman = 1'b0;
    snap_mode    = '0;
    snap_lo      = '0;
    snap_hi      = '0;
  endtask

  task automatic drop_lease();
    lease_held    = 1'b0;
    lease_token   = '0;
    lease_expiry  = '0;
    frame_seen    = 1'b0;
    last_frame_ms = '0;
    seq_valid     = 1'b0;
    last_seq      = '0;
    clear_snap();
  endtask

  // Neutral snapshot: axes and mode zero, active kept while the lease is held
  task automatic neutral_snap();
    clear_snap();
    snap_active = lease_held;
    frame_seen  = lease_held;
  endtask

  // Apply one command word to the shadow state and build the status it yields
  task automatic advance_lease(input item_t c, output result_t s);
    logic [63:0] tok;
    int unsigned tlen;
    logic [63:0] lo;
    logic [63:0] hi;
    bit          lo_ok;
    bit          hi_ok;
    logic        took;
    logic [31:0] age;
    took  = 1'b0;
    tok   = trim_token(c.token, tlen);
    lo_ok = lanes_in_range(c.axes_low, lo);
    hi_ok = lanes_in_range(c.axes_high, hi);
    case (c.cmd)
      CMD_GRANT: begin
        if (!lease_held && tlen != 0 && tlen <= TOKEN_BYTES &&
            c.lease_ms != 32'd0 && c.lease_ms <= cfg_max_lease) begin
          lease_token   = tok;
          lease_held    = 1'b1;
          lease_expiry  = c.now_ms + c.lease_ms;
          last_frame_ms = c.now_ms;
          frame_seen    = 1'b0;
          seq_valid     = 1'b0;
          last_seq      = '0;
          clear_snap();
          took = 1'b1;
        end
      end
      CMD_RELEASE: begin
        if (lease_held && tok == lease_token) begin
          drop_lease();
          took = 1'b1;
        end
      end
      CMD_FRAME: begin
        if (lease_held && tok == lease_token && ahead_of(c.now_ms, lease_expiry) &&
            c.quoted_timeout_ms == cfg_frame_timeout &&
            !(seq_valid && c.sequence_req <= last_seq) && lo_ok && hi_ok) begin
          snap_active   = 1'b1;
          snap_deadman  = 1'b1;
          snap_mode     = c.mode;
          snap_lo       = lo;
          snap_hi       = hi;
          frame_seen    = 1'b1;
          last_frame_ms = c.now_ms;
          last_seq      = c.sequence_req;
          seq_valid     = 1'b1;
          took = 1'b1;
        end
      end
      CMD_NEUTRAL: begin
        if (lease_held) begin
          neutral_snap();
          last_frame_ms = c.now_ms;
        end
      end
      CMD_TICK: begin
        if (lease_held) begin
          age = c.now_ms - last_frame_ms;
          if (!c.prereq_ok || !ahead_of(c.now_ms, lease_expiry)) begin
            drop_lease();
          end else if (frame_seen && age > cfg_frame_timeout) begin
            neutral_snap();
            last_frame_ms = c.now_ms;
          end
        end
      end
      default: ;  // spare codes leave everything alone
    endcase

    s.accepted       = took;
    s.authority      = lease_held;
    s.snap_active    = snap_active;
    s.deadman        = snap_deadman;
    s.snap_mode      = snap_mode;
    s.snap_axes_low  = snap_lo;
    s.snap_axes_high = snap_hi;
    s.frame_age_ms   = frame_seen ? c.now_ms - last_frame_ms : 32'd0;
    s.lease_left_ms  = (lease_held && ahead_of(c.now_ms, lease_expiry)) ?
                       lease_expiry - c.now_ms : 32'd0;
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("status word %0d %s: got %h, want %h",
                                words_checked, name, got, want));
  endtask

  // Track both streams and the config port on every rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_max_lease     = MAX_LEASE_RST;
      cfg_frame_timeout = FRAME_TIMEOUT_RST;
      drop_lease();
      status_due.delete();
      fail_count    = 0;
      words_checked = 0;
      outstanding  <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_MAX_LEASE:     cfg_max_lease = cfg_wdata;
          REG_FRAME_TIMEOUT: cfg_frame_timeout = cfg_wdata;
          default: ;
        endcase
      end

      if (in_tvalid && in_tready) begin
        {pad_bits, seen_cmd.prereq_ok, seen_cmd.quoted_timeout_ms, seen_cmd.axes_high,
         seen_cmd.axes_low, seen_cmd.mode, seen_cmd.sequence_req, seen_cmd.lease_ms,
         seen_cmd.now_ms, seen_cmd.token} = in_tdata;
        seen_cmd.cmd = in_tuser;
        advance_lease(seen_cmd, want_s);
        status_due.push_back(want_s);
      end

      if (out_tvalid && out_tready) begin
        got_s = out_tdata[$bits(result_t)-1:0];
        if (status_due.size() == 0) begin
          report_mismatch($sformatf("status word %0d arrived with none due", words_checked));
        end else begin
          want_s = status_due.pop_front();
          check_field("accepted", got_s.accepted, want_s.accepted);
          check_field("authority", got_s.authority, want_s.authority);
          check_field("snap_active", got_s.snap_active, want_s.snap_active);
          check_field("deadman", got_s.deadman, want_s.deadman);
          check_field("snap_mode", got_s.snap_mode, want_s.snap_mode);
          check_field("snap_axes_low", got_s.snap_axes_low, want_s.snap_axes_low);
          check_field("snap_axes_high", got_s.snap_axes_high, want_s.snap_axes_high);
          check_field("frame_age_ms", got_s.frame_age_ms, want_s.frame_age_ms);
          check_field("lease_left_ms", got_s.lease_left_ms, want_s.lease_left_ms);
        end
        words_checked++;
      end

      outstanding <= status_due.size();
    end
  end

endmodule

[tb/tb_control_lease_guard.sv]
// ----------------------------------------------------------------------------
// tb_control_lease_guard
// Stimulus and verdict for the lease guard. A directed run covers idle
// commands, refused grants, token trimming, wrapped expiry, sequence and axis
// limits, staleness and revocation; then randomized lease sessions run under
// several register settings with random gaps and back-pressure. Checking is
// left to the checker instance.
// ----------------------------------------------------------------------------
module tb_control_lease_guard;
  import clg_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1350;
  localparam int unsigned PHASES       = 6;
  localparam int          LANE_ONE     = 1 << (AXIS_BITS - 2);

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [CMD_W-1:0]      in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b1;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [TIME_W-1:0]     cfg_wdata  = '0;

  int unsigned fail_count;
  int unsigned outstanding;

  int unsigned gap_pct    = 0;
  int unsigned stall_pct  = 0;
  int unsigned ready_hold = 0;
  int unsigned items_sent = 0;

  // Session bookkeeping for the generator (a guess, not a prediction)
  logic [31:0] cur_max     = MAX_LEASE_RST;
  logic [31:0] cur_timeout = FRAME_TIMEOUT_RST;
  logic [31:0] sim_now     = '0;
  logic [31:0] sess_seq    = '0;
  logic [63:0] sess_token  = '0;
  logic        seq_started = 1'b0;

  always #4 clk = ~clk;

  control_lease_guard DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  lease_guard_checker status_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Idle length: mostly short, now and then long
  function automatic int unsigned pick_len();
    if ($urandom_range(9, 0) == 0) return $urandom_range(40, 12);
    return $urandom_range(3, 1);
  endfunction

  // Receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if ($urandom_range(99, 0) < stall_pct) begin
      out_tready <= 1'b0;
      ready_hold <= pick_len();
    end else begin
      out_tready <= 1'b1;
      ready_hold <= $urandom_range(6, 0);
    end
  end

  function automatic item_t random_item();
    item_t c;
    c.cmd               = 3'($urandom_range(7, 0));
    c.token             = {$urandom, $urandom};
    c.now_ms            = $urandom;
    c.lease_ms          = $urandom;
    c.sequence_req      = $urandom;
    c.mode              = 3'($urandom);
    c.axes_low          = {$urandom, $urandom};
    c.axes_high         = {$urandom, $urandom};
    c.quoted_timeout_ms = $urandom;
    c.prereq_ok         = 1'($urandom);
    return c;
  endfunction

  function automatic item_t grant_item(input logic [63:0] tok, input logic [31:0] now_t,
                                       input logic [31:0] lease);
    item_t c;
    c          = random_item();
    c.cmd      = CMD_GRANT;
    c.token    = tok;
    c.now_ms   = now_t;
    c.lease_ms = lease;
    return c;
  endfunction

  function automatic item_t frame_item(input logic [63:0] tok, input logic [31:0] now_t,
                                       input logic [31:0] seq, input logic [2:0] md,
                                       input logic [63:0] lo, input logic [63:0] hi,
                                       input logic [31:0] quoted);
    item_t c;
    c                   = random_item();
    c.cmd               = CMD_FRAME;
    c.token             = tok;
    c.now_ms            = now_t;
    c.sequence_req      = seq;
    c.mode              = md;
    c.axes_low          = lo;
    c.axes_high         = hi;
    c.quoted_timeout_ms = quoted;
    return c;
  endfunction

  function automatic item_t tick_item(input logic [31:0] now_t, input logic ok);
    item_t c;
    c           = random_item();
    c.cmd       = CMD_TICK;
    c.now_ms    = now_t;
    c.prereq_ok = ok;
    return c;
  endfunction

  // Release, neutral or a spare code
  function automatic item_t simple_item(input logic [2:0] code, input logic [63:0] tok,
                                        input logic [31:0] now_t);
    item_t c;
    c        = random_item();
    c.cmd    = code;
    c.token  = tok;
    c.now_ms = now_t;
    return c;
  endfunction

  // 1 to 8 nonzero bytes, zero above
  function automatic logic [63:0] make_token();
    logic [63:0] t;
    int unsigned n;
    t = '0;
    n = $urandom_range(8, 1);
    for (int i = 0; i < n; i++) t[8*i +: 8] = 8'($urandom_range(255, 1));
    return t;
  endfunction

  // Half the time, fill the bytes past the terminating zero with junk
  function automatic logic [63:0] with_junk(input logic [63:0] t);
    logic [63:0] r;
    bit          past;
    r    = t;
    past = 1'b0;
    if ($urandom_range(1, 0) == 0) return r;
    for (int i = 0; i < 8; i++) begin
      if (past) r[8*i +: 8] = 8'($urandom);
      if (t[8*i +: 8] == 8'd0) past = 1'b1;
    end
    return r;
  endfunction

  // Four lanes within +-1.0, sometimes right on the limits
  function automatic logic [63:0] in_range_axes();
    logic [63:0] w;
    int          v;
    w = '0;
    for (int i = 0; i < 4; i++) begin
      v = int'($urandom_range(2 * LANE_ONE, 0)) - LANE_ONE;
      if ($urandom_range(9, 0) == 0) v = ($urandom_range(1, 0) != 0) ? LANE_ONE : -LANE_ONE;
      w[16*i +: 16] = 16'(v);
    end
    return w;
  endfunction

  // One lane pushed past +-1.0
  function automatic logic [63:0] bad_axes();
    logic [63:0] w;
    w = in_range_axes();
    w[16*$urandom_range(3, 0) +: 16] =
      16'($urandom_range((1 << AXIS_BITS) - LANE_ONE - 1, LANE_ONE + 1));
    return w;
  endfunction

  function automatic logic [31:0] pick_lease();
    logic [31:0] lim;
    lim = (cur_max < 32'd2000) ? cur_max : 32'd2000;
    if ($urandom_range(1, 0) == 0) return $urandom_range(lim, 1);
    return $urandom_range(cur_max, 1);
  endfunction

  // Clock advance: mostly small, some at or just past the frame timeout, a few wild
  function automatic logic [31:0] next_step();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 25) return $urandom_range(2, 0);
    if (r < 80) return $urandom_range(120, 0);
    if (r < 93) return cur_timeout + $urandom_range(1, 0);
    return $urandom;
  endfunction

  function automatic item_t good_frame(input logic [31:0] seq);
    return frame_item(with_junk(sess_token), sim_now, seq, 3'($urandom),
                      in_range_axes(), in_range_axes(), cur_timeout);
  endfunction

  // A frame with exactly one defect
  function automatic item_t broken_frame();
    item_t c;
    c = good_frame(sess_seq + 32'd1);
    case ($urandom_range(4, 0))
      0: c.token = make_token();
      1: c.sequence_req = sess_seq - $urandom_range(2, 0);
      2: begin
        if ($urandom_range(1, 0) != 0) c.axes_low = bad_axes();
        else c.axes_high = bad_axes();
      end
      3: c.quoted_timeout_ms = cur_timeout ^ (32'd1 << $urandom_range(31, 0));
      default: c.now_ms = sim_now + 32'h8000_0000 + $urandom_range(1000, 0);
    endcase
    return c;
  endfunction

  // Offer one command word, hold it until taken, then maybe go idle
  task automatic send(input item_t c);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tuser  <= c.cmd;
    in_tdata  <= {4'b0, c.prereq_ok, c.quoted_timeout_ms, c.axes_high, c.axes_low,
                  c.mode, c.sequence_req, c.lease_ms, c.now_ms, c.token};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    gap = ($urandom_range(99, 0) < gap_pct) ? pick_len() : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Registers change only once every status word is back
  task automatic set_config(input logic [31:0] max_lease, input logic [31:0] timeout);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_MAX_LEASE;
    cfg_wdata <= max_lease;
    @(posedge clk);
    cfg_index <= REG_FRAME_TIMEOUT;
    cfg_wdata <= timeout;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cur_max     = max_lease;
    cur_timeout = timeout;
  endtask

  // Grant, a run of mostly good frames mixed with ticks and noise, then close
  task automatic run_session();
    item_t       c;
    logic [31:0] lease;
    int unsigned acts;
    int unsigned r;
    gap_pct     = 20 * $urandom_range(2, 0);
    stall_pct   = 20 * $urandom_range(2, 0);
    sess_token  = make_token();
    sess_seq    = ($urandom_range(9, 0) == 0) ? $urandom : $urandom_range(1000, 0);
    seq_started = 1'b0;
    sim_now     = sim_now + next_step();
    lease       = pick_lease();

    c = grant_item(with_junk(sess_token), sim_now, lease);
    r = $urandom_range(99, 0);
    if (r < 6) c.token = '0;
    else if (r < 9) c.token[7:0] = 8'd0;
    else if (r < 13) c.lease_ms = '0;
    else if (r < 17 && cur_max < 32'hFFFF_0000)
      c.lease_ms = cur_max + 32'd1 + $urandom_range(50, 0);
    send(c);

    acts = $urandom_range(30, 2);
    repeat (acts) begin
      sim_now = sim_now + next_step();
      r = $urandom_range(99, 0);
      if (r < 60) begin
        if (seq_started)
          sess_seq = sess_seq + 32'd1 +
                     (($urandom_range(3, 0) == 0) ? $urandom_range(1000, 0) : 0);
        seq_started = 1'b1;
        send(good_frame(sess_seq));
      end else if (r < 70) begin
        send(tick_item(sim_now, $urandom_range(19, 0) != 0));
      end else if (r < 75) begin
        send(simple_item(CMD_NEUTRAL, sess_token, sim_now));
      end else if (r < 88) begin
        send(broken_frame());
      end else if (r < 92) begin
        send(grant_item(make_token(), sim_now, pick_lease()));
      end else if (r < 96) begin
        send(simple_item(CMD_RELEASE, make_token(), sim_now));
      end else begin
        send(random_item());
      end
    end

    // Close the lease; now and then leave it standing for the next session
    sim_now = sim_now + next_step();
    r = $urandom_range(99, 0);
    if (r < 45) begin
      send(simple_item(CMD_RELEASE, with_junk(sess_token), sim_now));
    end else if (r < 65) begin
      send(tick_item(sim_now, 1'b0));
    end else if (r < 85) begin
      sim_now = sim_now + lease;
      send(tick_item(sim_now, 1'b1));
    end
  endtask

  // Run limit
  initial begin
    #5_000_000;
    $display("control_lease_guard verification failed");
    $finish;
  end

  initial begin
    logic [63:0] tok_a;
    logic [63:0] tok_b;
    logic [63:0] tok_full;
    int unsigned phase_start;
    logic [31:0] new_max;
    logic [31:0] new_timeout;
    tok_a    = 64'h0000_0000_0000_0041;
    tok_b    = 64'h0000_0000_0043_4241;
    tok_full = 64'hFFFF_FFFF_FFFF_FFFF;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, reset register values
    gap_pct   = 30;
    stall_pct = 30;
    // frame, release and neutral with no lease held
    send(frame_item(tok_a, 32'd100, 32'd1, 3'd3, '0, '0, 32'd500));
    send(simple_item(CMD_RELEASE, tok_a, 32'd100));
    send(simple_item(CMD_NEUTRAL, tok_a, 32'd100));
    // refused grants: empty token, zero lease, lease over the maximum
    send(grant_item(64'd0, 32'd100, 32'd100));
    send(grant_item(tok_a, 32'd100, 32'd0));
    send(grant_item(tok_a, 32'd100, 32'd30001));
    // junk past the terminating zero, max lease, expiry wraps past zero
    send(grant_item(64'hA5A5_A5A5_A5A5_0041, 32'hFFFF_FF00, 32'd30000));
    send(grant_item(64'h42, 32'hFFFF_FF01, 32'd10));
    send(frame_item(64'h42, 32'hFFFF_FF10, 32'd0, 3'd1, '0, '0, 32'd500));
    // lanes right on +1.0 and -1.0
    send(frame_item(64'hFFFF_FF00_0000_0041, 32'hFFFF_FF20, 32'd0, 3'd7,
                    64'hC000_4000_C000_4000, 64'h4000_C000_0000_FFFF, 32'd500));
    send(frame_item(tok_a, 32'hFFFF_FF30, 32'd0, 3'd2, '0, '0, 32'd500));
    send(frame_item(tok_a, 32'hFFFF_FF40, 32'd5, 3'd2, 64'h0000_4001_0000_0000, '0,
                    32'd500));
    send(frame_item(tok_a, 32'hFFFF_FF50, 32'd5, 3'd2, '0, 64'hBFFF_0000_0000_0000,
                    32'd500));
    send(frame_item(tok_a, 32'hFFFF_FF60, 32'd5, 3'd2, '0, '0, 32'd501));
    // top sequence number after the clock wrap; nothing can follow it
    send(frame_item(tok_a, 32'h0000_0010, 32'hFFFF_FFFF, 3'd0, '0, '0, 32'd500));
    send(frame_item(tok_a, 32'h0000_0020, 32'd0, 3'd4, '0, '0, 32'd500));
    // stale by one, then exactly at the limit
    send(tick_item(32'h0000_0205, 1'b1));
    send(tick_item(32'h0000_03F9, 1'b1));
    send(simple_item(CMD_NEUTRAL, tok_a, 32'h0000_0400));
    // two before expiry, then one before
    send(tick_item(32'h0000_742E, 1'b1));
    send(tick_item(32'h0000_742F, 1'b1));
    // full eight-byte token, minimum lease, lost prerequisites
    send(grant_item(tok_full, 32'd0, 32'd1));
    send(frame_item(tok_full, 32'd0, 32'd0, 3'd5, in_range_axes(), in_range_axes(),
                    32'd500));
    send(tick_item(32'd0, 1'b0));
    // release with the wrong token, then the right one
    send(grant_item(tok_b, 32'd1000, 32'd30000));
    send(simple_item(CMD_RELEASE, tok_a, 32'd1001));
    send(simple_item(CMD_RELEASE, tok_b, 32'd1002));
    // spare codes
    send(simple_item(3'd5, tok_b, 32'd1003));
    send(simple_item(3'd7, tok_b, 32'd1004));

    // Random sessions under several register settings
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          new_max     = 32'd1;
          new_timeout = 32'd1;
        end
        1: begin
          new_max     = 32'hFFFF_FFFF;
          new_timeout = 32'hFFFF_FFFF;
        end
        2: begin
          new_max     = $urandom_range(200, 1);
          new_timeout = $urandom_range(50, 1);
        end
        3: begin
          new_max     = $urandom_range(100000, 1);
          new_timeout = $urandom_range(2000, 1);
        end
        4: begin
          new_max     = 32'hFFFF_FFFF;
          new_timeout = $urandom_range(500, 1);
        end
        default: begin
          new_max     = MAX_LEASE_RST;
          new_timeout = FRAME_TIMEOUT_RST;
        end
      endcase
      set_config(new_max, new_timeout);
      phase_start = items_sent;
      while (items_sent - phase_start < RANDOM_ITEMS / PHASES) run_session();
    end

    // Drain, then let the pipeline settle
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("control_lease_guard verification clean");
    end else begin
      $display("control_lease_guard verification failed");
    end
    $finish;
  end

endmodule
